>>> rtl/gfbt_pkg.sv
`default_nettype none
package gfbt_pkg;
   localparam int TableDepth = 64;
   localparam int IdxBits = $clog2(TableDepth);
   localparam int CntBits = $clog2(TableDepth + 1);
   localparam int TimeBits = 32;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0, CMD_TRIED = 3'd1, CMD_FAILED = 3'd2, CMD_DONE = 3'd3,
      CMD_CHECK = 3'd4, CMD_LOOKUP = 3'd5, CMD_TICK = 3'd6, CMD_CLEAR = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_UNTRIED = 2'd0, ST_TRIED = 2'd1, ST_FAILED = 2'd2, ST_BLACK = 2'd3
   } status_type;

   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_THRESH = 2'd1;
   localparam logic [1:0] CSR_COOL = 2'd2;

   // search unit request/answer
   typedef struct packed {
      logic start;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
   } srch_req_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic [IdxBits-1:0] idx;
   } srch_rsp_type;
endpackage
`default_nettype wire

>>> rtl/gfbt_search.sv
`default_nettype none
// Walks entries 0..count-1 one at a time, each read in S_READ and tested in S_TEST, stops at first hit.
module gfbt_search (
   input  wire logic clock,
   input  wire logic reset,
   input  wire gfbt_pkg::srch_req_type req,
   input  wire logic [gfbt_pkg::CntBits-1:0] count,
   input  wire logic [11:0] radius,
   output logic [gfbt_pkg::IdxBits-1:0] rd_addr,
   input  wire logic [31:0] rd_point,
   output gfbt_pkg::srch_rsp_type rsp
);
   import gfbt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001, S_READ = 3'b010, S_TEST = 3'b100
   } sstate_type;

   sstate_type state_ff, state_in;
   logic [CntBits-1:0] idx_ff, idx_in;
   logic signed [15:0] gx_ff, gy_ff;
   logic [23:0] r2_ff;
   logic done_ff, done_in, hit_ff, hit_in;
   logic signed [16:0] dx, dy;
   logic [33:0] sq_x, sq_y;
   logic [34:0] d2;

   assign rd_addr = idx_ff[IdxBits-1:0];
   assign dx = 17'(signed'(rd_point[15:0])) - 17'(gx_ff);
   assign dy = 17'(signed'(rd_point[31:16])) - 17'(gy_ff);
   assign sq_x = 34'(dx * dx);
   assign sq_y = 34'(dy * dy);
   assign d2 = 35'(sq_x) + 35'(sq_y);

   always_ff @(posedge clock) begin
      if (req.start) begin
         gx_ff <= req.gx;
         gy_ff <= req.gy;
         r2_ff <= radius * radius;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      done_in = 1'b0;
      hit_in = hit_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               idx_in = '0;
               hit_in = 1'b0;
               if (count == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: state_in = S_TEST;
         S_TEST: begin
            if (d2 < 35'(r2_ff)) begin
               hit_in = 1'b1;
               done_in = 1'b1;
               state_in = S_IDLE;
            end else if (idx_ff + 1'b1 >= count) begin
               done_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         done_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         done_ff <= done_in;
         hit_ff <= hit_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.hit = hit_ff;
   assign rsp.idx = idx_ff[IdxBits-1:0];
endmodule
`default_nettype wire

>>> rtl/goal_failure_blacklist_table_top.sv
// Tick and clear need no search; other commands search the stored entries
// (to the first match or through all of them), then read, update and answer.
// One word at a time; the search walks one entry after another
// through a single distance unit and the entry memory read port.
// Reset (synchronous): table empty, time zero, registers at defaults.
`default_nettype none
module goal_failure_blacklist_table_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [2:0] req_cmd,
   input  wire logic signed [15:0] req_goal_x,
   input  wire logic signed [15:0] req_goal_y,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_found,
   output logic [5:0] rsp_entry_index,
   output logic [1:0] rsp_goal_status,
   output logic [7:0] rsp_failures,
   output logic rsp_is_blacklisted,
   output logic rsp_table_full,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [31:0] csr_data
);
   import gfbt_pkg::*;

   typedef enum logic [4:0] {
      M_IDLE = 5'b00001, M_SRCH = 5'b00010, M_RD = 5'b00100,
      M_UPD = 5'b01000, M_OUT = 5'b10000
   } mstate_type;

   mstate_type state_ff;
   logic [11:0] radius_ff;
   logic [7:0] thresh_ff;
   logic [23:0] cool_ff;
   logic [CntBits-1:0] count_ff;
   logic [TimeBits-1:0] now_ff;
   cmd_type cmd_ff;
   logic signed [15:0] gx_ff, gy_ff;
   logic [IdxBits-1:0] idx_ff;
   logic hit_ff;

   // entry memories
   logic [31:0] mem_point [TableDepth];
   logic [9:0] mem_sf [TableDepth];
   logic [TimeBits-1:0] mem_rel [TableDepth];
   logic [31:0] pt_rd;
   logic [9:0] sf_rd;
   logic [TimeBits-1:0] rel_rd;

   srch_req_type sreq;
   srch_rsp_type srsp;
   logic [IdxBits-1:0] s_addr;
   logic req_take;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == M_IDLE) && !rsp_valid;
   assign req_take = req_valid && req_ready;

   // tick and clear need no search
   assign sreq.start = req_take && req_cmd != CMD_TICK && req_cmd != CMD_CLEAR;
   assign sreq.gx = req_goal_x;
   assign sreq.gy = req_goal_y;

   gfbt_search u_search (
      .clock(clock), .reset(reset), .req(sreq), .count(count_ff),
      .radius(radius_ff), .rd_addr(s_addr), .rd_point(pt_rd), .rsp(srsp)
   );

   logic [IdxBits-1:0] rd_a;
   assign rd_a = (state_ff == M_SRCH) ? s_addr : idx_ff;

   // update computation
   logic is_add, is_upd, can_add, wr_en;
   logic [1:0] st_new;
   logic [7:0] f_new, f_inc;
   logic [TimeBits-1:0] rel_new;
   logic black_new;

   assign is_add = cmd_ff == CMD_ADD || cmd_ff == CMD_TRIED || cmd_ff == CMD_FAILED;
   assign can_add = count_ff < CntBits'(TableDepth);

   always_comb begin
      st_new = hit_ff ? sf_rd[9:8] : ST_UNTRIED;
      f_new = hit_ff ? sf_rd[7:0] : 8'd0;
      rel_new = hit_ff ? rel_rd : '0;
      black_new = 1'b0;
      f_inc = (f_new == 8'hFF) ? f_new : f_new + 8'd1;
      case (cmd_ff)
         CMD_TRIED: st_new = ST_TRIED;
         CMD_FAILED: begin
            f_new = f_inc;
            if (f_inc >= thresh_ff) begin
               st_new = ST_BLACK;
               rel_new = now_ff + TimeBits'(cool_ff);
            end else begin
               st_new = ST_FAILED;
            end
         end
         CMD_DONE: begin
            st_new = ST_UNTRIED;
            f_new = 8'd0;
         end
         CMD_CHECK: begin
            if (st_new == ST_BLACK && now_ff > rel_new) begin
               st_new = ST_UNTRIED;
               f_new = 8'd0;
            end
            black_new = st_new == ST_BLACK;
         end
         default: ;
      endcase
   end

   assign is_upd = hit_ff || (is_add && can_add);
   assign wr_en = (state_ff == M_UPD) && is_upd;

   always_ff @(posedge clock) begin
      pt_rd <= mem_point[rd_a];
      sf_rd <= mem_sf[rd_a];
      rel_rd <= mem_rel[rd_a];
      if (wr_en) begin
         // a matched entry keeps its stored point
         if (!hit_ff) mem_point[idx_ff] <= {gy_ff, gx_ff};
         mem_sf[idx_ff] <= {st_new, f_new};
         mem_rel[idx_ff] <= rel_new;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (sreq.start) begin
         cmd_ff <= cmd_type'(req_cmd);
         gx_ff <= req_goal_x;
         gy_ff <= req_goal_y;
      end
      if (state_ff == M_SRCH && srsp.done) begin
         hit_ff <= srsp.hit;
         idx_ff <= srsp.hit ? srsp.idx : count_ff[IdxBits-1:0];
      end
      if (state_ff == M_UPD) begin
         rsp_found <= is_upd;
         rsp_entry_index <= is_upd ? 6'(idx_ff) : 6'd0;
         rsp_goal_status <= is_upd ? st_new : ST_UNTRIED;
         rsp_failures <= is_upd ? f_new : 8'd0;
         rsp_is_blacklisted <= hit_ff && black_new;
         rsp_table_full <= !hit_ff && is_add && !can_add;
      end else if (req_take && (req_cmd == CMD_TICK || req_cmd == CMD_CLEAR)) begin
         rsp_found <= 1'b0;
         rsp_entry_index <= 6'd0;
         rsp_goal_status <= ST_UNTRIED;
         rsp_failures <= 8'd0;
         rsp_is_blacklisted <= 1'b0;
         rsp_table_full <= 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         rsp_valid <= 1'b0;
         count_ff <= '0;
         now_ff <= '0;
         radius_ff <= 12'd50;
         thresh_ff <= 8'd3;
         cool_ff <= 24'd60000;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_RADIUS: radius_ff <= csr_data[11:0];
               CSR_THRESH: thresh_ff <= csr_data[7:0];
               CSR_COOL: cool_ff <= csr_data[23:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (req_take) begin
                  if (req_cmd == CMD_TICK) begin
                     now_ff <= now_ff + 1'b1;
                     rsp_valid <= 1'b1;
                  end else if (req_cmd == CMD_CLEAR) begin
                     count_ff <= '0;
                     rsp_valid <= 1'b1;
                  end else begin
                     state_ff <= M_SRCH;
                  end
               end
            end
            M_SRCH: if (srsp.done) state_ff <= M_RD;
            M_RD: state_ff <= M_UPD;
            M_UPD: begin
               if (!hit_ff && is_add && can_add) count_ff <= count_ff + 1'b1;
               state_ff <= M_OUT;
            end
            M_OUT: begin
               rsp_valid <= 1'b1;
               state_ff <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/gfbt_checker.sv
`default_nettype none
module gfbt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_found,
   input wire logic [5:0] rsp_entry_index,
   input wire logic [7:0] rsp_failures,
   input wire logic rsp_is_blacklisted,
   input wire logic rsp_table_full
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second word taken");
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_found) else $error("full with found");
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_entry_index == 6'd0 && rsp_failures == 8'd0
         && !rsp_is_blacklisted) else $error("fields without entry");
endmodule

bind goal_failure_blacklist_table_top gfbt_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
   .rsp_entry_index(rsp_entry_index), .rsp_failures(rsp_failures),
   .rsp_is_blacklisted(rsp_is_blacklisted), .rsp_table_full(rsp_table_full)
);
`default_nettype wire

>>> tb/goal_table_checker.sv
`timescale 1ns / 1ps
module goal_table_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire logic [2:0] req_cmd,
   input  wire logic signed [15:0] req_goal_x,
   input  wire logic signed [15:0] req_goal_y,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic rsp_found,
   input  wire logic [5:0] rsp_entry_index,
   input  wire logic [1:0] rsp_goal_status,
   input  wire logic [7:0] rsp_failures,
   input  wire logic rsp_is_blacklisted,
   input  wire logic rsp_table_full,
   input  wire logic csr_valid,
   input  wire logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [31:0] csr_data,
   output int error_count,
   output int pending_count,
   output int result_count
);
   import gfbt_pkg::*;

   typedef struct packed {
      logic found;
      logic [5:0] index;
      logic [1:0] status;
      logic [7:0] failures;
      logic black;
      logic full;
   } answer_type;

   answer_type answer_q[$];

   // shadow table
   logic [11:0] radius;
   logic [7:0] threshold;
   logic [23:0] cooldown;
   int unsigned count;
   logic signed [15:0] px [TableDepth];
   logic signed [15:0] py [TableDepth];
   status_type stat [TableDepth];
   logic [7:0] fails [TableDepth];
   logic [TimeBits-1:0] release_at [TableDepth];
   logic [TimeBits-1:0] now;

   function automatic int nearest_goal(logic signed [15:0] gx, logic signed [15:0] gy);
      longint dx, dy, r2;
      r2 = longint'(radius) * longint'(radius);
      for (int i = 0; i < count; i++) begin
         dx = longint'(px[i]) - longint'(gx);
         dy = longint'(py[i]) - longint'(gy);
         if (dx * dx + dy * dy < r2) return i;
      end
      return -1;
   endfunction

   function automatic int place_goal(logic signed [15:0] gx, logic signed [15:0] gy,
                                     ref logic full);
      int i;
      i = nearest_goal(gx, gy);
      if (i >= 0) return i;
      if (count >= TableDepth) begin
         full = 1'b1;
         return -1;
      end
      i = count;
      px[i] = gx;
      py[i] = gy;
      stat[i] = ST_UNTRIED;
      fails[i] = '0;
      release_at[i] = '0;
      count++;
      return i;
   endfunction

   function automatic answer_type apply_command(cmd_type cmd, logic signed [15:0] gx,
                                                logic signed [15:0] gy);
      answer_type a;
      int i;
      logic full, black;
      i = -1;
      full = 1'b0;
      black = 1'b0;
      case (cmd)
         CMD_ADD: i = place_goal(gx, gy, full);
         CMD_TRIED: begin
            i = place_goal(gx, gy, full);
            if (i >= 0) stat[i] = ST_TRIED;
         end
         CMD_FAILED: begin
            i = place_goal(gx, gy, full);
            if (i >= 0) begin
               if (fails[i] != 8'hFF) fails[i]++;
               if (fails[i] >= threshold) begin
                  stat[i] = ST_BLACK;
                  release_at[i] = now + TimeBits'(cooldown);
               end else begin
                  stat[i] = ST_FAILED;
               end
            end
         end
         CMD_DONE: begin
            i = nearest_goal(gx, gy);
            if (i >= 0) begin
               fails[i] = '0;
               stat[i] = ST_UNTRIED;
            end
         end
         CMD_CHECK: begin
            i = nearest_goal(gx, gy);
            if (i >= 0) begin
               // lapsed blacklist is released here
               if (stat[i] == ST_BLACK && now > release_at[i]) begin
                  stat[i] = ST_UNTRIED;
                  fails[i] = '0;
               end
               black = (stat[i] == ST_BLACK);
            end
         end
         CMD_LOOKUP: i = nearest_goal(gx, gy);
         CMD_TICK: now = now + 1'b1;
         default: count = 0;
      endcase
      a = '0;
      if (i >= 0) begin
         a.found = 1'b1;
         a.index = 6'(i);
         a.status = stat[i];
         a.failures = fails[i];
      end
      a.black = black;
      a.full = full;
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         radius <= 12'd50;
         threshold <= 8'd3;
         cooldown <= 24'd60000;
         count = 0;
         now = '0;
         answer_q.delete();
         error_count <= 0;
         result_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIUS: radius <= csr_data[11:0];
               CSR_THRESH: threshold <= csr_data[7:0];
               CSR_COOL: cooldown <= csr_data[23:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            answer_q.insert(answer_q.size(),
                            apply_command(cmd_type'(req_cmd), req_goal_x, req_goal_y));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_found, rsp_entry_index, rsp_goal_status, rsp_failures,
                   rsp_is_blacklisted, rsp_table_full};
            result_count <= result_count + 1;
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = answer_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected f=%b i=%0d s=%0d n=%0d b=%b full=%b",
                           $time, want.found, want.index, want.status, want.failures,
                           want.black, want.full);
                  $display("%0t:            actual f=%b i=%0d s=%0d n=%0d b=%b full=%b",
                           $time, got.found, got.index, got.status, got.failures,
                           got.black, got.full);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_count <= answer_q.size();
   end
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import gfbt_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [2:0] req_cmd = '0;
   logic signed [15:0] req_goal_x = '0, req_goal_y = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic rsp_found, rsp_is_blacklisted, rsp_table_full;
   logic [5:0] rsp_entry_index;
   logic [1:0] rsp_goal_status;
   logic [7:0] rsp_failures;
   logic csr_valid = 1'b0, csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   int error_count, pending_count, result_count;
   int cycle_count = 0;
   logic signed [15:0] spot_x [8];
   logic signed [15:0] spot_y [8];

   always #6 clock = ~clock;

   goal_failure_blacklist_table_top dut (.*);
   goal_table_checker checker_i (.*);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side stalls
   initial begin
      int w;
      forever begin
         @(posedge clock);
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // valid stays up after an accept when the next word follows at once
   task automatic send_word(cmd_type c, logic signed [15:0] x, logic signed [15:0] y,
                            bit no_gap = 0);
      int w;
      w = no_gap ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
         req_valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_goal_x <= x;
      req_goal_y <= y;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || req_valid);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly goals near a few hot spots so entries get reused
   task automatic random_word();
      int s, r;
      logic signed [15:0] x, y;
      cmd_type c;
      r = $urandom_range(0, 99);
      if (r < 15) c = CMD_ADD;
      else if (r < 27) c = CMD_TRIED;
      else if (r < 50) c = CMD_FAILED;
      else if (r < 58) c = CMD_DONE;
      else if (r < 72) c = CMD_CHECK;
      else if (r < 80) c = CMD_LOOKUP;
      else if (r < 98) c = CMD_TICK;
      else c = CMD_CLEAR;
      if ($urandom_range(0, 9) < 8) begin
         s = $urandom_range(0, 7);
         x = spot_x[s] + 16'($signed($urandom_range(0, 20)) - 10);
         y = spot_y[s] + 16'($signed($urandom_range(0, 20)) - 10);
      end else begin
         x = 16'($urandom);
         y = 16'($urandom);
      end
      send_word(c, x, y, $urandom_range(0, 4) == 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every command, blacklist and clear
      send_word(CMD_LOOKUP, 0, 0);
      send_word(CMD_ADD, 16'sh7FFF, 16'sh7FFF);
      send_word(CMD_ADD, -16'sh8000, -16'sh8000);
      send_word(CMD_ADD, 16'sh7FFF, -16'sh8000);
      send_word(CMD_ADD, 16'sh7FF0, 16'sh7FF0);
      send_word(CMD_TRIED, 100, 100);
      send_word(CMD_FAILED, 100, 100);
      send_word(CMD_FAILED, 110, 100);
      send_word(CMD_FAILED, 100, 120);
      send_word(CMD_FAILED, 100, 100);
      send_word(CMD_CHECK, 100, 100);
      send_word(CMD_DONE, 100, 100);
      send_word(CMD_DONE, 5000, 5000);
      send_word(CMD_CHECK, 5000, 5000);
      send_word(CMD_TICK, 16'sh1234, 16'sh5678);
      send_word(CMD_CLEAR, 0, 0);
      send_word(CMD_LOOKUP, 16'sh7FFF, 16'sh7FFF);
      drain_results();

      // short cooldown, threshold one, then expiry on tick
      write_reg(CSR_THRESH, 1);
      write_reg(CSR_COOL, 1);
      send_word(CMD_FAILED, 7, 7);
      send_word(CMD_CHECK, 7, 7);
      send_word(CMD_TICK, 0, 0);
      send_word(CMD_CHECK, 7, 7);
      send_word(CMD_TICK, 0, 0);
      send_word(CMD_CHECK, 7, 7);
      drain_results();

      // zero radius: every add makes a new entry, overflow the table
      write_reg(CSR_RADIUS, 0);
      write_reg(CSR_THRESH, 0);
      for (int i = 0; i < 66; i++) send_word(CMD_ADD, 16'(i), 16'(i), 1);
      send_word(CMD_TRIED, 1, 1);
      send_word(CMD_FAILED, 2, 2);
      send_word(CMD_CLEAR, 0, 0);
      drain_results();

      // random phases over several settings, extremes among them
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin write_reg(CSR_RADIUS, 50); write_reg(CSR_THRESH, 3);
                      write_reg(CSR_COOL, 5); end
            1: begin write_reg(CSR_RADIUS, 4095); write_reg(CSR_THRESH, 255);
                      write_reg(CSR_COOL, 24'hFFFFFF); end
            2: begin write_reg(CSR_RADIUS, 1); write_reg(CSR_THRESH, 1);
                      write_reg(CSR_COOL, 2); end
            3: begin write_reg(CSR_RADIUS, 30); write_reg(CSR_THRESH, 2);
                      write_reg(CSR_COOL, 3); end
            4: begin write_reg(CSR_RADIUS, $urandom_range(0, 4095));
                      write_reg(CSR_THRESH, $urandom_range(0, 255));
                      write_reg(CSR_COOL, $urandom); end
            default: begin write_reg(CSR_RADIUS, 20); write_reg(CSR_THRESH, 4);
                      write_reg(CSR_COOL, 10); end
         endcase
         for (int s = 0; s < 8; s++) begin
            spot_x[s] = 16'($urandom);
            spot_y[s] = 16'($urandom);
         end
         for (int n = 0; n < 100; n++) random_word();
         drain_results();
      end

      $display("Covered: all eight commands, blacklist and expiry, full table,");
      $display("  and %0d results checked over nine register settings.", result_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
